// ===== hw/rtl/dtmf_tgf_pkg.sv =====
// DTMF tone generator package: sine polynomial constants, per-tone phase steps,
// key decode and register indexes. No dependencies.

package dtmf_tgf_pkg;

  localparam int unsigned RATE_HZ    = 44100;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_TONE_KEY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_IN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT     = 2'd3;

  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Horner terms of the quarter sine, innermost first
  localparam int unsigned NUM_TERMS = 5;
  localparam int unsigned TERM_SH [NUM_TERMS] = '{7, 7, 6, 5, 3};
  localparam logic [32:0] TERM_M [NUM_TERMS] = '{
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };

  // Row tones 697, 770, 852, 941 Hz; column tones 1209, 1336, 1477 Hz
  localparam int unsigned NUM_LO = 4;
  localparam int unsigned NUM_HI = 3;

  localparam logic [31:0] STEP_Q_LO [NUM_LO] = '{
    32'((64'd697 << 32) / 64'(RATE_HZ)),
    32'((64'd770 << 32) / 64'(RATE_HZ)),
    32'((64'd852 << 32) / 64'(RATE_HZ)),
    32'((64'd941 << 32) / 64'(RATE_HZ))
  };
  localparam logic [15:0] STEP_R_LO [NUM_LO] = '{
    16'((64'd697 << 32) % 64'(RATE_HZ)),
    16'((64'd770 << 32) % 64'(RATE_HZ)),
    16'((64'd852 << 32) % 64'(RATE_HZ)),
    16'((64'd941 << 32) % 64'(RATE_HZ))
  };
  localparam logic [31:0] STEP_Q_HI [NUM_HI] = '{
    32'((64'd1209 << 32) / 64'(RATE_HZ)),
    32'((64'd1336 << 32) / 64'(RATE_HZ)),
    32'((64'd1477 << 32) / 64'(RATE_HZ))
  };
  localparam logic [15:0] STEP_R_HI [NUM_HI] = '{
    16'((64'd1209 << 32) % 64'(RATE_HZ)),
    16'((64'd1336 << 32) % 64'(RATE_HZ)),
    16'((64'd1477 << 32) % 64'(RATE_HZ))
  };

  // quo[31:30] is the quadrant, quo[29:0] the Q30 fraction within it
  typedef struct packed {
    logic [31:0] quo;
    logic [15:0] rem;
  } phase_t;

  typedef struct packed {
    logic [30:0] y;
    logic [31:0] y2;
    logic [31:0] w;
  } lane_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] lo;
    logic [1:0] hi;
  } key_sel_t;

  function automatic phase_t phase_step(input phase_t ph, input logic [31:0] sq,
                                        input logic [15:0] sr);
    phase_t      nx;
    logic [16:0] rs;
    logic        c;
    rs     = 17'(ph.rem) + 17'(sr);
    c      = (rs >= 17'(RATE_HZ));
    nx.rem = c ? 16'(rs - 17'(RATE_HZ)) : 16'(rs);
    nx.quo = ph.quo + sq + 32'(c);
    return nx;
  endfunction

  function automatic key_sel_t key_decode(input logic [3:0] key);
    key_sel_t ks;
    ks = '{ok: 1'b1, lo: 2'd0, hi: 2'd0};
    case (key)
      4'd0: begin ks.lo = 2'd3; ks.hi = 2'd1; end
      4'd1: begin ks.lo = 2'd0; ks.hi = 2'd0; end
      4'd2: begin ks.lo = 2'd0; ks.hi = 2'd1; end
      4'd3: begin ks.lo = 2'd0; ks.hi = 2'd2; end
      4'd4: begin ks.lo = 2'd1; ks.hi = 2'd0; end
      4'd5: begin ks.lo = 2'd1; ks.hi = 2'd1; end
      4'd6: begin ks.lo = 2'd1; ks.hi = 2'd2; end
      4'd7: begin ks.lo = 2'd2; ks.hi = 2'd0; end
      4'd8: begin ks.lo = 2'd2; ks.hi = 2'd1; end
      4'd9: begin ks.lo = 2'd2; ks.hi = 2'd2; end
      4'd10: begin ks.lo = 2'd3; ks.hi = 2'd0; end
      4'd11: begin ks.lo = 2'd3; ks.hi = 2'd2; end
      default: begin ks.ok = 1'b0; end
    endcase
    return ks;
  endfunction

endpackage

// ===== hw/rtl/dtmf_tone_generator_fade_unit.sv =====
// DTMF tone generator with linear fade envelope, top level.
// Depends on dtmf_tgf_pkg.

// One signed 16-bit sample per input transaction, one transaction per clock
// sustained while the output is not stalled. Samples pass through the two
// quarter-sine pipelines (one multiply per stage, thirteen multiply stages)
// and then the sum, gain and fade-divide stages. Tone phases are kept as
// exact quotient/remainder accumulators, one per tone frequency, so no table or
// divider sits on the phase path. Ready drops only when every stage holds a
// sample and the output is stalled. Registers are written through the plain
// write port and take effect on the next transaction; only reset restarts a
// finished tone.

module dtmf_tone_generator_fade_unit #(
  parameter int unsigned TONE_PERIOD = 44100,
  parameter int unsigned FADE_LEN    = 882
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dtmf_tgf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dtmf_tgf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                stopping_i,
  input  logic [15:0]                         remaining_in_request_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [15:0]                  sample_o,
  output logic                                last_sample_o,
  output logic                                finished_o
);
  import dtmf_tgf_pkg::*;

  localparam int unsigned POS_W    = $clog2(TONE_PERIOD);
  localparam int unsigned GAIN_W   = $clog2(FADE_LEN + 1);
  localparam int unsigned FL_SH    = $clog2(FADE_LEN);
  localparam int unsigned MAG_W    = GAIN_W + 14;
  localparam int unsigned PROD_W   = 17 + GAIN_W;
  localparam logic [MAG_W+1:0] FL_M = (MAG_W + 2)'(
    ((64'd1 << (MAG_W + FL_SH)) + 64'(FADE_LEN) - 64'd1) / 64'(FADE_LEN));

  localparam int unsigned LANE_STG = 4 + 2 * NUM_TERMS;
  localparam int unsigned RAW_STG  = LANE_STG;
  localparam int unsigned PROD_STG = LANE_STG + 1;
  localparam int unsigned OUT_STG  = LANE_STG + 2;
  localparam int unsigned NSTG     = OUT_STG + 1;

  typedef struct packed {
    logic              neg_lo;
    logic              neg_hi;
    logic              silent;
    logic [GAIN_W-1:0] gain;
    logic              last;
    logic              fin;
  } side_t;

  logic [3:0]  tone_key_q;
  logic [23:0] play_samples_q;
  logic        fade_in_q;
  logic        fade_out_q;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [23:0]      played_q, played_d;
  logic             done_q, done_d;
  phase_t           ph_lo_q [NUM_LO];
  phase_t           ph_lo_d [NUM_LO];
  phase_t           ph_hi_q [NUM_HI];
  phase_t           ph_hi_d [NUM_HI];

  logic            in_fire;
  logic            timed;
  logic            fin;
  logic            last;
  logic            pos_wrap;
  logic [GAIN_W-1:0] gain;
  key_sel_t        ks;
  phase_t          sel_lo, sel_hi;
  logic [31:0]     arg_lo, arg_hi;
  side_t           side_d;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;
  lane_t           lane_q [2][LANE_STG];
  lane_t           lane_d [2][LANE_STG];
  side_t           side_q [PROD_STG+1];

  logic signed [15:0]       raw_q, raw_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [15:0]       sample_q, sample_d;
  logic                     last_q, fin_q;

  // Handshake and bubble-collapsing stage enables
  assign en[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign in_ready_o = en[0];
  assign in_fire    = in_valid_i && in_ready_o;

  // Envelope and end-of-tone decisions
  assign timed = (play_samples_q != '0);
  assign fin   = done_q || (timed && (played_q >= play_samples_q));
  assign last  = (timed && ((25'(played_q) + 25'd1) == 25'(play_samples_q))) ||
                 (stopping_i && (remaining_in_request_i <= 16'd1));

  always_comb begin
    if (fin) begin
      gain = '0;
    end else if (fade_in_q && (played_q < 24'(FADE_LEN))) begin
      gain = GAIN_W'(played_q);
    end else if (fade_out_q && timed &&
                 ((25'(played_q) + 25'(FADE_LEN)) >= 25'(play_samples_q))) begin
      gain = GAIN_W'(play_samples_q - played_q);
    end else if (fade_out_q && stopping_i &&
                 (remaining_in_request_i <= 16'(FADE_LEN))) begin
      gain = GAIN_W'(remaining_in_request_i);
    end else begin
      gain = GAIN_W'(FADE_LEN);
    end
  end

  // Phase selection and quadrant folding
  assign ks     = key_decode(tone_key_q);
  assign sel_lo = ph_lo_q[ks.lo];
  assign sel_hi = ph_hi_q[ks.hi];
  assign arg_lo = sel_lo.quo[30] ? 32'(Q30_ONE) - {2'b00, sel_lo.quo[29:0]}
                                 : {2'b00, sel_lo.quo[29:0]};
  assign arg_hi = sel_hi.quo[30] ? 32'(Q30_ONE) - {2'b00, sel_hi.quo[29:0]}
                                 : {2'b00, sel_hi.quo[29:0]};

  always_comb begin
    side_d.neg_lo = sel_lo.quo[31];
    side_d.neg_hi = sel_hi.quo[31];
    side_d.silent = !ks.ok;
    side_d.gain   = gain;
    side_d.last   = last && !fin;
    side_d.fin    = fin;
  end

  // Tone state advance
  assign pos_wrap = (pos_q == POS_W'(TONE_PERIOD - 1));

  for (genvar i = 0; i < NUM_LO; i++) begin : g_ph_lo
    assign ph_lo_d[i] = pos_wrap ? '0 : phase_step(ph_lo_q[i], STEP_Q_LO[i], STEP_R_LO[i]);
  end
  for (genvar i = 0; i < NUM_HI; i++) begin : g_ph_hi
    assign ph_hi_d[i] = pos_wrap ? '0 : phase_step(ph_hi_q[i], STEP_Q_HI[i], STEP_R_HI[i]);
  end

  assign pos_d    = pos_wrap ? '0 : pos_q + POS_W'(1);
  assign played_d = (played_q != '1) ? played_q + 24'd1 : played_q;
  assign done_d   = done_q || fin || last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_key_q     <= '0;
      play_samples_q <= '0;
      fade_in_q      <= 1'b1;
      fade_out_q     <= 1'b1;
      pos_q          <= '0;
      played_q       <= '0;
      done_q         <= 1'b0;
      for (int i = 0; i < NUM_LO; i++) ph_lo_q[i] <= '0;
      for (int i = 0; i < NUM_HI; i++) ph_hi_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TONE_KEY:     tone_key_q     <= cfg_wdata_i[3:0];
          REG_PLAY_SAMPLES: play_samples_q <= cfg_wdata_i[23:0];
          REG_FADE_IN:      fade_in_q      <= cfg_wdata_i[0];
          REG_FADE_OUT:     fade_out_q     <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        done_q <= done_d;
        if (!fin) begin
          pos_q    <= pos_d;
          played_q <= played_d;
          for (int i = 0; i < NUM_LO; i++) ph_lo_q[i] <= ph_lo_d[i];
          for (int i = 0; i < NUM_HI; i++) ph_hi_q[i] <= ph_hi_d[i];
        end
      end
    end
  end

  // Quarter-sine lanes: y, y^2, five Horner terms, final product
  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign lane_d[l][0] = '{y: '0, y2: '0, w: (l == 0) ? arg_lo : arg_hi};
    for (genvar s = 1; s < LANE_STG; s++) begin : g_stg
      if (s == 1) begin : g_y
        logic [62:0] p;
        assign p = lane_q[l][s-1].w * HALF_PI_Q30;
        assign lane_d[l][s] = '{y: 31'(p >> 30), y2: '0, w: '0};
      end else if (s == 2) begin : g_y2
        logic [61:0] p;
        assign p = lane_q[l][s-1].y * lane_q[l][s-1].y;
        assign lane_d[l][s] = '{y: lane_q[l][s-1].y, y2: 32'(p >> 30), w: 32'(Q30_ONE)};
      end else if (s == LANE_STG - 1) begin : g_fin
        logic [62:0] p;
        assign p = lane_q[l][s-1].y * lane_q[l][s-1].w;
        assign lane_d[l][s] = '{y: lane_q[l][s-1].y, y2: lane_q[l][s-1].y2, w: 32'(p >> 30)};
      end else if ((s % 2) == 1) begin : g_mul
        logic [63:0] p;
        assign p = lane_q[l][s-1].y2 * lane_q[l][s-1].w;
        assign lane_d[l][s] = '{y: lane_q[l][s-1].y, y2: lane_q[l][s-1].y2, w: 32'(p >> 30)};
      end else begin : g_div
        localparam int unsigned K = (s - 4) / 2;
        logic [64:0] p;
        logic [31:0] q;
        assign p = lane_q[l][s-1].w * TERM_M[K];
        assign q = 32'(p >> (32 + TERM_SH[K]));
        assign lane_d[l][s] = '{y: lane_q[l][s-1].y, y2: lane_q[l][s-1].y2,
                                w: 32'(Q30_ONE) - q};
      end
    end
  end

  // Sum of tones, truncated toward zero
  logic signed [33:0] s_lo, s_hi, s_sum, s_bias, s_shr;
  always_comb begin
    s_lo   = $signed({2'b00, lane_q[0][LANE_STG-1].w});
    s_hi   = $signed({2'b00, lane_q[1][LANE_STG-1].w});
    if (side_q[RAW_STG-1].neg_lo) s_lo = -s_lo;
    if (side_q[RAW_STG-1].neg_hi) s_hi = -s_hi;
    s_sum  = s_lo + s_hi;
    s_bias = s_sum[33] ? 34'sd131071 : 34'sd0;
    s_shr  = (s_sum + s_bias) >>> 17;
    raw_d  = side_q[RAW_STG-1].silent ? 16'sd0 : 16'(s_shr);
  end

  // Gain and fade divide
  assign prod_d = raw_q * $signed({1'b0, side_q[PROD_STG-1].gain});

  logic [MAG_W-1:0]   mag;
  logic [2*MAG_W+1:0] qp;
  logic [15:0]        q16;
  always_comb begin
    mag      = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
    qp       = mag * FL_M;
    q16      = 16'(qp >> (MAG_W + FL_SH));
    sample_d = prod_q[PROD_W-1] ? -$signed(q16) : $signed(q16);
  end

  // Pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0]    <= side_d;
      lane_q[0][0] <= lane_d[0][0];
      lane_q[1][0] <= lane_d[1][0];
    end
    for (int k = 1; k < LANE_STG; k++) begin
      if (en[k]) begin
        side_q[k]    <= side_q[k-1];
        lane_q[0][k] <= lane_d[0][k];
        lane_q[1][k] <= lane_d[1][k];
      end
    end
    if (en[RAW_STG]) begin
      side_q[RAW_STG] <= side_q[RAW_STG-1];
      raw_q           <= raw_d;
    end
    if (en[PROD_STG]) begin
      side_q[PROD_STG] <= side_q[PROD_STG-1];
      prod_q           <= prod_d;
    end
    if (en[OUT_STG]) begin
      sample_q <= sample_d;
      last_q   <= side_q[PROD_STG].last;
      fin_q    <= side_q[PROD_STG].fin;
    end
  end

  assign out_valid_o   = vld_q[OUT_STG];
  assign sample_o      = sample_q;
  assign last_sample_o = last_q;
  assign finished_o    = fin_q;

endmodule

// ===== hw/rtl/dtmf_tgf_chk.sv =====
// Port-level checker for the DTMF tone generator and its bind statement.
// Depends only on the top level's ports.

module dtmf_tgf_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] sample_o,
  input logic               last_sample_o,
  input logic               finished_o
);

  logic ended_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && (last_sample_o || finished_o)) begin
      ended_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o) &&
                                    $stable(last_sample_o) && $stable(finished_o))
    else $error("output transaction changed while stalled");

  a_fin_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> (sample_o == 16'sd0) && !last_sample_o)
    else $error("finished transaction carries a sample");

  a_stay_ended: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ended_q |-> finished_o)
    else $error("sample delivered after the tone ended");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_o >= -16'sd16384) && (sample_o <= 16'sd16384))
    else $error("sample exceeds two-tone full scale");

  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind dtmf_tone_generator_fade_unit dtmf_tgf_chk u_dtmf_tgf_chk (.*);

// ===== test/dtmf_tone_generator_fade_unit_test.sv =====
// Self-checking testbench for dtmf_tone_generator_fade_unit: a bit-exact sample predictor,
// directed and random request streams, register changes between drained phases.
// Depends on dtmf_tgf_pkg and the unit RTL only.
`timescale 1ns / 100ps

module dtmf_tone_generator_fade_unit_test;

  import dtmf_tgf_pkg::*;

  localparam int unsigned TONE_PERIOD = 44100;
  localparam int          FADE_LEN    = 882;
  localparam int unsigned SAMPLE_HZ   = 44100;
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          SETTLE_CYCLES = 40;

  localparam longint unsigned Q30_UNIT = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  localparam logic [3:0] KEY_ZERO  = 4'd0;
  localparam logic [3:0] KEY_ONE   = 4'd1;
  localparam logic [3:0] KEY_POUND = 4'd11;
  localparam logic [3:0] KEY_LAST  = 4'd15;

  localparam int unsigned ROW_HZ [12] = '{941, 697, 697, 697, 770, 770, 770, 852, 852, 852,
                                          941, 941};
  localparam int unsigned COL_HZ [12] = '{1336, 1209, 1336, 1477, 1209, 1336, 1477, 1209,
                                          1336, 1477, 1209, 1477};

  typedef struct packed {
    logic        stopping;
    logic [15:0] remaining;
  } tone_req_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               finished;
  } tone_out_t;

  typedef enum logic [1:0] {END_TIMED, END_STOP_ONE, END_STOP_ZERO, END_LENGTH} tone_end_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  stopping_i = 1'b0;
  logic [15:0]           remaining_in_request_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [15:0]    sample_o;
  logic                  last_sample_o;
  logic                  finished_o;

  tone_req_t req_q [$];
  tone_out_t due_samples [$];
  bit        gaps_on = 1'b1;
  int        send_gap = 0;
  int        stall_left = 0;
  int        items_queued = 0;
  int        items_taken = 0;
  int        settings = 0;
  int        fault_count = 0;

  logic [3:0]  key_cfg = KEY_ZERO;
  logic [23:0] length_cfg = '0;
  logic        fade_in_cfg = 1'b1;
  logic        fade_out_cfg = 1'b1;
  logic [15:0] tab_pos = '0;
  logic [23:0] played = '0;
  logic        ended = 1'b0;

  dtmf_tone_generator_fade_unit uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .stopping_i             (stopping_i),
    .remaining_in_request_i (remaining_in_request_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .sample_o               (sample_o),
    .last_sample_o          (last_sample_o),
    .finished_o             (finished_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint unsigned quarter_sine(input longint unsigned x);
    longint unsigned y, y2, a;
    y  = (x * Q30_HALF_PI) >> 30;
    y2 = (y * y) >> 30;
    a  = Q30_UNIT - y2 / 110;
    a  = Q30_UNIT - ((y2 * a) >> 30) / 72;
    a  = Q30_UNIT - ((y2 * a) >> 30) / 42;
    a  = Q30_UNIT - ((y2 * a) >> 30) / 20;
    a  = Q30_UNIT - ((y2 * a) >> 30) / 6;
    return (y * a) >> 30;
  endfunction

  function automatic longint unit_sine(input int unsigned f, input int unsigned j);
    longint unsigned ph, t, quad, x, s;
    ph   = (longint'(f) * longint'(j)) % SAMPLE_HZ;
    t    = 4 * ph;
    quad = t / SAMPLE_HZ;
    x    = ((t % SAMPLE_HZ) << 30) / SAMPLE_HZ;
    s    = ((quad & 1) != 0) ? quarter_sine(Q30_UNIT - x) : quarter_sine(x);
    return ((quad & 2) != 0) ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint dual_tone(input logic [3:0] key, input int unsigned j);
    if (key > KEY_POUND) return 0;
    return (unit_sine(ROW_HZ[key], j) + unit_sine(COL_HZ[key], j)) / 131072;
  endfunction

  function automatic tone_out_t next_tone_sample(input logic stop, input logic [15:0] rem);
    tone_out_t   res;
    longint      n, p, r, x, y;
    int unsigned pos;
    logic        fin;
    n   = longint'(played);
    p   = longint'(length_cfg);
    r   = longint'(rem);
    res = '0;
    if (ended || (p > 0 && n >= p)) begin
      ended = 1'b1;
      res.finished = 1'b1;
      return res;
    end
    pos = (tab_pos >= TONE_PERIOD) ? 0 : tab_pos;
    x   = dual_tone(key_cfg, pos);
    if (fade_in_cfg && n < FADE_LEN) begin
      y = x * n / FADE_LEN;
    end else if (fade_out_cfg && p > 0 && n + FADE_LEN >= p) begin
      y = x * (p - n) / FADE_LEN;
    end else if (fade_out_cfg && stop && r <= FADE_LEN) begin
      y = x * r / FADE_LEN;
    end else begin
      y = x;
    end
    fin = (p > 0 && n + 1 == p) || (stop && r <= 1);
    pos++;
    if (pos >= TONE_PERIOD) pos = 0;
    tab_pos = 16'(pos);
    if (played != 24'hFFFFFF) played++;
    if (fin) ended = 1'b1;
    res.sample = 16'(y);
    res.last   = fin;
    return res;
  endfunction

  task automatic log_fault(input string what, input tone_out_t want, input tone_out_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected sample %0d last %0b finished %0b, got sample %0d last %0b %s %0b",
               what, want.sample, want.last, want.finished, got.sample, got.last,
               "finished", got.finished);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    tone_req_t item;
    logic      take;
    if (!rst_ni) begin
      in_valid_i             <= 1'b0;
      stopping_i             <= 1'b0;
      remaining_in_request_i <= '0;
      send_gap               <= 0;
    end else begin
      take = in_valid_i && in_ready_o;
      if (!in_valid_i || take) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (req_q.size() > 0) begin
          item = req_q.pop_front();
          in_valid_i             <= 1'b1;
          stopping_i             <= item.stopping;
          remaining_in_request_i <= item.remaining;
          if (gaps_on && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 16);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    tone_out_t got, want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{sample_o, last_sample_o, finished_o};
        if (due_samples.size() == 0) begin
          log_fault("sample with nothing pending", '0, got);
        end else begin
          want = due_samples.pop_front();
          if (got.sample !== want.sample || got.last !== want.last ||
              got.finished !== want.finished) begin
            log_fault("sample mismatch", want, got);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        due_samples.push_back(next_tone_sample(stopping_i, remaining_in_request_i));
        items_taken++;
      end
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left  <= $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void add_req(input logic stop, input logic [15:0] rem);
    req_q.push_back('{stop, rem});
    items_queued++;
  endfunction

  function automatic void add_random_req();
    logic        stop;
    logic [15:0] rem;
    stop = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: rem = 16'($urandom_range(2, FADE_LEN));
      1: rem = 16'($urandom_range(FADE_LEN - 2, FADE_LEN + 2));
      default: rem = 16'($urandom_range(0, 16'hFFFF));
    endcase
    // keep the tone running
    if (stop && rem < 2) rem = 2;
    add_req(stop, rem);
  endfunction

  task automatic drain();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_valid_i || due_samples.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TONE_KEY:     key_cfg = value[3:0];
      REG_PLAY_SAMPLES: length_cfg = value[23:0];
      REG_FADE_IN:      fade_in_cfg = value[0];
      REG_FADE_OUT:     fade_out_cfg = value[0];
      default: ;
    endcase
    settings++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    tone_end_e   ending;
    int          i, count, start, lead;
    logic        countdown;
    logic [23:0] length;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fade-in from reset values
    add_req(1'b0, 16'hFFFF);
    add_req(1'b0, 16'h0000);
    add_req(1'b0, 16'h0001);
    add_req(1'b1, 16'hFFFF);
    add_req(1'b1, 16'h0002);
    add_req(1'b1, 16'(FADE_LEN));
    drain();
    write_reg(REG_FADE_IN, CFG_DATA_W'(1'b0));
    write_reg(REG_TONE_KEY, CFG_DATA_W'(KEY_LAST));
    write_reg(REG_PLAY_SAMPLES, 24'hFFFFFF);
    add_req(1'b1, 16'd500);
    add_req(1'b0, 16'h5555);
    drain();
    // stop fade boundaries
    write_reg(REG_TONE_KEY, CFG_DATA_W'(KEY_POUND));
    write_reg(REG_PLAY_SAMPLES, '0);
    add_req(1'b1, 16'(FADE_LEN + 1));
    add_req(1'b1, 16'(FADE_LEN));
    add_req(1'b1, 16'(FADE_LEN - 1));
    add_req(1'b1, 16'd2);
    add_req(1'b0, 16'hAAAA);
    add_req(1'b0, 16'h0001);
    drain();
    write_reg(REG_FADE_OUT, CFG_DATA_W'(1'b0));
    add_req(1'b1, 16'd3);
    add_req(1'b1, 16'd100);
    drain();
    // timed fade starts on the second sample
    write_reg(REG_FADE_OUT, CFG_DATA_W'(1'b1));
    write_reg(REG_TONE_KEY, CFG_DATA_W'(KEY_ONE));
    write_reg(REG_PLAY_SAMPLES, played + 24'(FADE_LEN + 1));
    add_req(1'b0, 16'hFFFF);
    add_req(1'b1, 16'd10);
    add_req(1'b0, 16'd7);
    add_req(1'b1, 16'hFFFF);
    drain();

    while (items_queued < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      count   = $urandom_range(20, 120);
      if ($urandom_range(0, 4) == 0) begin
        write_reg(REG_TONE_KEY, CFG_DATA_W'($urandom_range(KEY_POUND + 1, KEY_LAST)));
      end else begin
        write_reg(REG_TONE_KEY, CFG_DATA_W'($urandom_range(KEY_ZERO, KEY_POUND)));
      end
      write_reg(REG_FADE_IN, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(REG_FADE_OUT, CFG_DATA_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 4))
        0, 1: length = '0;
        2: length = 24'hFFFFFF;
        default: length = played + 24'(count) + 24'($urandom_range(1, 900));
      endcase
      write_reg(REG_PLAY_SAMPLES, length);
      countdown = 1'($urandom_range(0, 1));
      start     = $urandom_range(2, FADE_LEN + count);
      for (i = 0; i < count; i++) begin
        if (countdown) begin
          add_req($urandom_range(0, 4) != 0, 16'((start > i + 2) ? start - i : 2));
        end else begin
          add_random_req();
        end
      end
      drain();
    end

    gaps_on = 1'b0;
    ending  = tone_end_e'($urandom_range(0, 3));
    lead    = $urandom_range(0, 20);
    case (ending)
      END_TIMED:  write_reg(REG_PLAY_SAMPLES, played + 24'($urandom_range(1, 20)));
      END_LENGTH: write_reg(REG_PLAY_SAMPLES, 24'($urandom_range(1, played)));
      default:    write_reg(REG_PLAY_SAMPLES, '0);
    endcase
    for (i = 0; i < 40; i++) begin
      if (ending == END_STOP_ONE && i == lead) begin
        add_req(1'b1, 16'd1);
      end else if (ending == END_STOP_ZERO && i == lead) begin
        add_req(1'b1, 16'd0);
      end else begin
        add_random_req();
      end
    end
    drain();
    // a finished tone stays finished
    write_reg(REG_PLAY_SAMPLES, '0);
    write_reg(REG_TONE_KEY, CFG_DATA_W'($urandom_range(KEY_ZERO, KEY_POUND)));
    for (i = 0; i < 10; i++) add_random_req();
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    fault_count += due_samples.size();
    $display("%0d requests checked across %0d register writes; tone ended by %s",
             items_taken, settings, ending.name());
    if (fault_count == 0) begin
      $display("dtmf_tone_generator_fade_unit_test: clean");
    end else begin
      $display("dtmf_tone_generator_fade_unit_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("dtmf_tone_generator_fade_unit_test: errors");
    $finish;
  end

endmodule
